### rtl/sbf_pkg.sv
`timescale 1ns / 1ps

package sbf_pkg;

  localparam int PAT_MAX  = 32;
  localparam int MAX_TEXT = 65536;
  localparam int LEN_W    = $clog2(PAT_MAX + 2);
  localparam int CNT_W    = $clog2(MAX_TEXT + 2);
  localparam int POS_W    = 16;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 32;

  typedef logic [7:0]        byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CFG_AW-1:0] cfg_addr_t;
  typedef logic [CFG_DW-1:0] cfg_data_t;

  localparam pos_t      POS_MAX  = '1;
  localparam cfg_addr_t ADDR_DIR = '0;

  typedef enum logic {
    MODE_PATTERN = 1'b0,
    MODE_TEXT    = 1'b1
  } mode_t;

  typedef struct packed {
    logic pat_load;
    logic text_shift;
    logic text_clear;
  } cell_ctrl_t;

endpackage

### rtl/sbf_ifs.sv
`timescale 1ns / 1ps

interface sbf_in_if;
  import sbf_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output mode, output data_byte, output last_byte,
                  input ready);
  modport sink (input valid, input mode, input data_byte, input last_byte,
                output ready);
endinterface

interface sbf_out_if;
  import sbf_pkg::*;

  logic valid;
  logic ready;
  logic found;
  pos_t position;
  logic pattern_too_long;
  logic text_overflow;

  modport source (output valid, output found, output position,
                  output pattern_too_long, output text_overflow, input ready);
  modport sink (input valid, input found, input position,
                input pattern_too_long, input text_overflow, output ready);
endinterface

### rtl/substring_search_first_last.sv
`timescale 1ns / 1ps
// the result item is registered at the edge that accepts the final text item
// throughput: one pattern or text item per cycle, set by the combinational compare across
//   the cell row; a waiting result does not block input unless it stays untaken
// reset: synchronous active low; clears direction, pattern length, window valid bits,
//   counters and output valid; pattern and window bytes are not cleared

module substring_search_first_last (
  input  logic              clk,
  input  logic              rst_n,
  sbf_in_if.sink            in_ch,
  sbf_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  sbf_pkg::cfg_addr_t cfg_paddr,
  input  sbf_pkg::cfg_data_t cfg_pwdata,
  output sbf_pkg::cfg_data_t cfg_prdata,
  output logic              cfg_pready
);
  import sbf_pkg::*;

  function automatic pos_t sat_pos(input logic [31:0] v);
    return (v > 32'(POS_MAX)) ? POS_MAX : v[POS_W-1:0];
  endfunction

  logic dir_r;

  len_t len_r, len_nxt;
  logic done_r, done_nxt;
  cnt_t cnt_r, cnt_nxt, cnt_inc;
  logic seen_r, seen_nxt;
  pos_t mpos_r, mpos_nxt;

  logic out_valid_r, out_valid_nxt;
  logic found_r, found_nxt;
  pos_t pos_r, pos_nxt;
  logic tl_r, tl_nxt;
  logic ovf_r, ovf_nxt;

  logic in_acc, pat_acc, txt_acc, txt_last, restart;
  len_t len_eff;
  logic len_ok, too_long, overflow, match;
  pos_t start;
  cell_ctrl_t ctrl;

  byte_t pat_a [PAT_MAX];
  byte_t win_a [PAT_MAX];
  byte_t pat_in_a [PAT_MAX];
  byte_t win_in_a [PAT_MAX];
  logic [PAT_MAX-1:0] act_a, wv_a, act_in_a, wv_in_a, hit_a;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_DIR) ? {{(CFG_DW-1){1'b0}}, dir_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == ADDR_DIR)) begin
      dir_r <= cfg_pwdata[0];
    end
  end

  // handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign pat_acc     = in_acc && (in_ch.mode == MODE_PATTERN);
  assign txt_acc     = in_acc && (in_ch.mode == MODE_TEXT);
  assign txt_last    = txt_acc && in_ch.last_byte;
  assign restart     = pat_acc && done_r;
  assign len_eff     = done_r ? '0 : len_r;

  assign ctrl.pat_load   = pat_acc && (len_eff < LEN_W'(PAT_MAX));
  assign ctrl.text_shift = txt_acc;
  assign ctrl.text_clear = restart || txt_last;

  // cell row
  for (genvar j = 0; j < PAT_MAX; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign pat_in_a[j] = in_ch.data_byte;
      assign win_in_a[j] = in_ch.data_byte;
      assign act_in_a[j] = 1'b1;
      assign wv_in_a[j]  = 1'b1;
    end else begin : g_link
      assign pat_in_a[j] = pat_a[j-1];
      assign win_in_a[j] = win_a[j-1];
      assign act_in_a[j] = act_a[j-1] && !restart;
      assign wv_in_a[j]  = wv_a[j-1];
    end

    sbf_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .pat_in  (pat_in_a[j]),
      .act_in  (act_in_a[j]),
      .win_in  (win_in_a[j]),
      .wv_in   (wv_in_a[j]),
      .pat_out (pat_a[j]),
      .act_out (act_a[j]),
      .win_out (win_a[j]),
      .wv_out  (wv_a[j]),
      .hit     (hit_a[j])
    );
  end

  // match tracking
  assign len_ok   = (len_r != '0) && (len_r <= LEN_W'(PAT_MAX));
  assign too_long = len_r > LEN_W'(PAT_MAX);
  assign match    = txt_acc && len_ok && (&hit_a);
  assign cnt_inc  = (cnt_r <= CNT_W'(MAX_TEXT)) ? cnt_r + 1'b1 : cnt_r;
  assign overflow = cnt_inc > CNT_W'(MAX_TEXT);
  assign start    = overflow ? POS_MAX : sat_pos(32'(cnt_inc) - 32'(len_r));

  always_comb begin
    len_nxt  = len_r;
    done_nxt = done_r;
    if (pat_acc) begin
      done_nxt = in_ch.last_byte;
      if (len_eff < LEN_W'(PAT_MAX)) begin
        len_nxt = len_eff + 1'b1;
      end else begin
        len_nxt = LEN_W'(PAT_MAX + 1);
      end
    end else if (txt_acc) begin
      done_nxt = 1'b1;
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    seen_nxt = seen_r;
    mpos_nxt = mpos_r;
    if (txt_acc) begin
      cnt_nxt = cnt_inc;
      if (match && (dir_r || !seen_r)) begin
        seen_nxt = 1'b1;
        mpos_nxt = start;
      end
    end
  end

  // result item
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    tl_nxt        = tl_r;
    ovf_nxt       = ovf_r;
    if (txt_last) begin
      out_valid_nxt = 1'b1;
      tl_nxt        = too_long;
      ovf_nxt       = overflow;
      if (too_long) begin
        found_nxt = 1'b0;
        pos_nxt   = '0;
      end else if (len_r == '0) begin
        found_nxt = 1'b1;
        pos_nxt   = dir_r ? sat_pos(32'(cnt_inc)) : '0;
      end else begin
        found_nxt = seen_nxt;
        pos_nxt   = seen_nxt ? mpos_nxt : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      done_r      <= 1'b0;
      cnt_r       <= '0;
      seen_r      <= 1'b0;
      mpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      if (ctrl.text_clear) begin
        cnt_r  <= '0;
        seen_r <= 1'b0;
        mpos_r <= '0;
      end else begin
        cnt_r  <= cnt_nxt;
        seen_r <= seen_nxt;
        mpos_r <= mpos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
    tl_r    <= tl_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.found            = found_r;
  assign out_ch.position         = pos_r;
  assign out_ch.pattern_too_long = tl_r;
  assign out_ch.text_overflow    = ovf_r;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    txt_last |=> out_valid_r)
    else $error("final text item gave no result");

  a_pattern_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    pat_acc |=> !out_valid_r)
    else $error("pattern item produced a result");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(PAT_MAX + 1))
    else $error("pattern length out of range");

  a_too_long_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(found_r && tl_r))
    else $error("too long pattern reported as found");

  a_cleared_after_text: assert property (@(posedge clk) disable iff (!rst_n)
    txt_last |=> (cnt_r == '0) && !seen_r && (wv_a == '0))
    else $error("text state not cleared after final item");

endmodule

### rtl/sbf_cell.sv
`timescale 1ns / 1ps

module sbf_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  sbf_pkg::cell_ctrl_t ctrl,
  input  sbf_pkg::byte_t     pat_in,
  input  logic               act_in,
  input  sbf_pkg::byte_t     win_in,
  input  logic               wv_in,
  output sbf_pkg::byte_t     pat_out,
  output logic               act_out,
  output sbf_pkg::byte_t     win_out,
  output logic               wv_out,
  output logic               hit
);
  import sbf_pkg::*;

  byte_t pat_r;
  byte_t win_r;
  logic  act_r;
  logic  wv_r;

  // pattern byte and window byte, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.pat_load) begin
      pat_r <= pat_in;
    end
    if (ctrl.text_shift) begin
      win_r <= win_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      wv_r  <= 1'b0;
    end else begin
      if (ctrl.pat_load) begin
        act_r <= act_in;
      end
      if (ctrl.text_clear) begin
        wv_r <= 1'b0;
      end else if (ctrl.text_shift) begin
        wv_r <= wv_in;
      end
    end
  end

  // compare against the byte that moves in on this item
  assign hit     = !act_r || (wv_in && (win_in == pat_r));
  assign pat_out = pat_r;
  assign act_out = act_r;
  assign win_out = win_r;
  assign wv_out  = wv_r;

endmodule

### bench/substring_search_checker.sv
`timescale 1ns / 1ps

module substring_search_checker
  import sbf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  sbf_in_if         in_ch,
  sbf_out_if        out_ch,
  input  logic      cfg_psel,
  input  logic      cfg_penable,
  input  logic      cfg_pwrite,
  input  cfg_addr_t cfg_paddr,
  input  cfg_data_t cfg_pwdata,
  input  cfg_data_t cfg_prdata,
  input  logic      cfg_pready,
  output int        errors,
  output int        pending
);

  typedef struct packed {
    logic found;
    pos_t position;
    logic pattern_too_long;
    logic text_overflow;
  } search_result_t;

  search_result_t search_results_q[$];

  byte_t pat_mem [PAT_MAX];
  len_t  pat_len;
  logic  pat_closed;
  byte_t win [PAT_MAX];
  len_t  win_fill;
  cnt_t  txt_cnt;
  logic  hit_seen;
  pos_t  hit_pos;
  logic  dir_rev;
  int    err_cnt = 0;

  function automatic pos_t clip16(int unsigned v);
    return (v > 32'hFFFF) ? POS_MAX : pos_t'(v);
  endfunction

  function automatic logic window_hit();
    int   base;
    int   k;
    logic ok;
    if (pat_len == 0 || pat_len > PAT_MAX) return 1'b0;
    if (win_fill < pat_len) return 1'b0;
    base = PAT_MAX - int'(pat_len);
    ok = 1'b1;
    for (k = 0; k < int'(pat_len); k++) begin
      if (pat_mem[k] != win[base + k]) ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic clear_text();
    int k;
    for (k = 0; k < PAT_MAX; k++) win[k] = '0;
    win_fill = '0;
    txt_cnt  = '0;
    hit_seen = 1'b0;
    hit_pos  = '0;
  endtask

  task automatic search_step(mode_t m, byte_t b, logic last);
    search_result_t r;
    pos_t           start;
    int             k;
    if (m == MODE_PATTERN) begin
      if (pat_closed) begin
        pat_len    = '0;
        pat_closed = 1'b0;
        clear_text();
      end
      if (pat_len < PAT_MAX) begin
        pat_mem[pat_len] = b;
        pat_len = pat_len + 1'b1;
      end else begin
        pat_len = len_t'(PAT_MAX + 1);
      end
      if (last) pat_closed = 1'b1;
    end else begin
      pat_closed = 1'b1;
      for (k = 0; k < PAT_MAX - 1; k++) win[k] = win[k + 1];
      win[PAT_MAX - 1] = b;
      if (win_fill < PAT_MAX) win_fill = win_fill + 1'b1;
      if (txt_cnt <= MAX_TEXT) txt_cnt = txt_cnt + 1'b1;
      if (window_hit()) begin
        if (txt_cnt > MAX_TEXT) start = POS_MAX;
        else start = clip16(int'(txt_cnt) - int'(pat_len));
        if (dir_rev || !hit_seen) begin
          hit_pos  = start;
          hit_seen = 1'b1;
        end
      end
      if (last) begin
        r.pattern_too_long = (pat_len > PAT_MAX);
        r.text_overflow    = (txt_cnt > MAX_TEXT);
        if (r.pattern_too_long) begin
          r.found    = 1'b0;
          r.position = '0;
        end else if (pat_len == 0) begin
          r.found    = 1'b1;
          r.position = dir_rev ? clip16(int'(txt_cnt)) : '0;
        end else begin
          r.found    = hit_seen;
          r.position = hit_seen ? hit_pos : '0;
        end
        search_results_q.push_back(r);
        clear_text();
      end
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    search_result_t want;
    if (!rst_n) begin
      dir_rev    = 1'b0;
      pat_len    = '0;
      pat_closed = 1'b0;
      clear_text();
      search_results_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == ADDR_DIR) begin
        if (cfg_pwrite) dir_rev = cfg_pwdata[0];
        else check_field("search_direction", int'(dir_rev), cfg_prdata);
      end
      if (in_ch.valid && in_ch.ready)
        search_step(in_ch.mode, in_ch.data_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (search_results_q.size() == 0) begin
          $error("result item with none expected: found %0d position %0d",
                 out_ch.found, out_ch.position);
          err_cnt++;
        end else begin
          want = search_results_q.pop_front();
          check_field("found", want.found, out_ch.found);
          check_field("position", want.position, out_ch.position);
          check_field("pattern_too_long", want.pattern_too_long, out_ch.pattern_too_long);
          check_field("text_overflow", want.text_overflow, out_ch.text_overflow);
        end
      end
    end
    errors  <= err_cnt;
    pending <= search_results_q.size();
  end

endmodule

### bench/substring_search_first_last_test.sv
`timescale 1ns / 1ps

module substring_search_first_last_test;
  import sbf_pkg::*;

  typedef byte_t byte_q_t[$];

  logic      clk;
  logic      rst_n;
  logic      cfg_psel;
  logic      cfg_penable;
  logic      cfg_pwrite;
  cfg_addr_t cfg_paddr;
  cfg_data_t cfg_pwdata;
  cfg_data_t cfg_prdata;
  logic      cfg_pready;
  int        errors;
  int        pending;

  int      idle_pct   = 0;
  int      stall_pct  = 0;
  int      hold_req   = 0;
  int      items_sent = 0;
  int      texts_sent = 0;
  byte_t   sym [3]    = '{default: '0};
  byte_q_t cur_pat;

  sbf_in_if  in_ch ();
  sbf_out_if out_ch ();

  substring_search_first_last u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  substring_search_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("substring_search_first_last_test: errors");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_ack;
    int hold_left;
    hold_ack  = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  function automatic byte_t pick_byte();
    if ($urandom_range(0, 9) == 0) return byte_t'($urandom_range(0, 255));
    return sym[$urandom_range(0, 2)];
  endfunction

  task automatic send_item(mode_t m, byte_t b, logic last);
    while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_bytes(mode_t m, byte_q_t q, logic close);
    int i;
    for (i = 0; i < q.size(); i++) send_item(m, q[i], close && (i == q.size() - 1));
    if (close && m == MODE_TEXT) texts_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, cfg_data_t d);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= ADDR_DIR;
    cfg_pwdata  <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_direction(logic rev);
    drain();
    apb_access(1'b1, cfg_data_t'(rev));
    apb_access(1'b0, '0);
  endtask

  task automatic make_pattern();
    int r;
    int n;
    sym[0] = byte_t'($urandom_range(0, 255));
    sym[1] = byte_t'($urandom_range(0, 255));
    sym[2] = byte_t'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 60) n = $urandom_range(1, 4);
    else if (r < 80) n = $urandom_range(5, 12);
    else if (r < 90) n = $urandom_range(13, 31);
    else if (r < 95) n = PAT_MAX;
    else n = $urandom_range(PAT_MAX + 1, PAT_MAX + 4);
    cur_pat.delete();
    repeat (n) cur_pat.push_back(pick_byte());
  endtask

  task automatic make_text(int max_len, output byte_q_t q);
    int n;
    int at;
    int j;
    q.delete();
    n = $urandom_range(1, max_len);
    repeat (n) q.push_back(pick_byte());
    repeat (2) begin
      if (cur_pat.size() <= n && $urandom_range(0, 99) < 60) begin
        at = $urandom_range(0, n - cur_pat.size());
        for (j = 0; j < cur_pat.size(); j++) q[at + j] = cur_pat[j];
      end
    end
  endtask

  task automatic run_phase(int n_items, int n_texts);
    int      first_items;
    int      first_texts;
    int      kind;
    mode_t   m;
    logic    l;
    byte_q_t q;
    first_items = items_sent;
    first_texts = texts_sent;
    while (items_sent - first_items < n_items || texts_sent - first_texts < n_texts) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        // noise
        repeat ($urandom_range(1, 6)) begin
          m = mode_t'($urandom_range(0, 1));
          l = 1'($urandom_range(0, 1));
          send_item(m, byte_t'($urandom_range(0, 255)), l);
          if (m == MODE_TEXT && l) texts_sent++;
        end
      end else if (kind < 25) begin
        // text left open, often cut off by a new pattern
        repeat ($urandom_range(1, 5)) send_item(MODE_TEXT, pick_byte(), 1'b0);
      end else begin
        make_pattern();
        send_bytes(MODE_PATTERN, cur_pat, kind >= 35);
        repeat ($urandom_range(1, 3)) begin
          make_text(($urandom_range(0, 99) < 15) ? 40 : 12, q);
          send_bytes(MODE_TEXT, q, 1'b1);
        end
      end
    end
    make_pattern();
    send_bytes(MODE_PATTERN, cur_pat, 1'b1);
    make_text(12, q);
    send_bytes(MODE_TEXT, q, 1'b1);
  endtask

  initial begin
    byte_q_t q;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_PATTERN;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= ADDR_DIR;
    cfg_pwdata      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pattern, forward then reverse, then reverse past the counter limit
    q = {8'h00, 8'hFF, 8'h5A};
    send_bytes(MODE_TEXT, q, 1'b1);
    set_direction(1'b1);
    q = {8'hFF};
    send_bytes(MODE_TEXT, q, 1'b1);
    q.delete();
    repeat (MAX_TEXT + 2) q.push_back(byte_t'($urandom_range(0, 255)));
    send_bytes(MODE_TEXT, q, 1'b1);

    set_direction(1'b0);
    q = {8'hFF, 8'h00};
    send_bytes(MODE_PATTERN, q, 1'b1);
    q = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
    send_bytes(MODE_TEXT, q, 1'b1);
    set_direction(1'b1);
    send_bytes(MODE_TEXT, q, 1'b1);

    set_direction(1'b0);
    // overlong pattern
    q.delete();
    repeat (PAT_MAX + 1) q.push_back(byte_t'($urandom_range(0, 255)));
    send_bytes(MODE_PATTERN, q, 1'b1);
    q = {8'hAA};
    send_bytes(MODE_TEXT, q, 1'b1);
    // pattern longer than text
    q = {8'h01, 8'h02, 8'h03};
    send_bytes(MODE_PATTERN, q, 1'b1);
    q = {8'h01, 8'h02};
    send_bytes(MODE_TEXT, q, 1'b1);
    // pattern closed by the first text item
    q = {8'h80};
    send_bytes(MODE_PATTERN, q, 1'b0);
    send_bytes(MODE_TEXT, q, 1'b1);
    // new pattern drops a partial text
    q = {8'h5A};
    send_bytes(MODE_PATTERN, q, 1'b1);
    send_bytes(MODE_TEXT, q, 1'b0);
    q = {8'hA5};
    send_bytes(MODE_PATTERN, q, 1'b1);
    q = {8'h5A, 8'hA5};
    send_bytes(MODE_TEXT, q, 1'b1);
    // text overflow, forward hit at the start, reverse hit past the limit
    q = {8'hC3, 8'h3C};
    send_bytes(MODE_PATTERN, q, 1'b1);
    q = {8'hC3, 8'h3C};
    repeat (MAX_TEXT + 4) q.push_back(byte_t'($urandom_range(0, 255)));
    send_bytes(MODE_TEXT, q, 1'b1);
    set_direction(1'b1);
    q.delete();
    repeat (MAX_TEXT + 4) q.push_back(byte_t'($urandom_range(0, 255)));
    q.push_back(8'hC3);
    q.push_back(8'h3C);
    send_bytes(MODE_TEXT, q, 1'b1);

    set_direction(1'b0);
    run_phase(110, 10);

    set_direction(1'b1);
    idle_pct = 53;
    run_phase(110, 10);

    set_direction(1'b0);
    idle_pct  = 0;
    stall_pct = 53;
    run_phase(110, 10);

    // long receiver hold-off while short texts keep coming
    set_direction(1'b1);
    stall_pct = 0;
    make_pattern();
    send_bytes(MODE_PATTERN, cur_pat, 1'b1);
    hold_req++;
    repeat (24) begin
      make_text(2, q);
      send_bytes(MODE_TEXT, q, 1'b1);
    end

    set_direction(1'($urandom_range(0, 1)));
    idle_pct  = 25;
    stall_pct = 25;
    run_phase(110, 10);

    drain();
    if (errors == 0) begin
      $display("substring_search_first_last_test: clean");
    end else begin
      $display("substring_search_first_last_test: errors");
    end
    $finish;
  end

endmodule
